// ===== rtl/core/assert_macros.svh =====
// assertion helpers used by the checker file cfgc_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define CFGC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: implication failed");

// next-cycle implication, disabled in reset
`define CFGC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

`endif

// ===== rtl/core/cfgc_pkg.sv =====
package cfgc_pkg;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_PIN  = 2'd1,
        CMD_POLL = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_SINGLE = 3'd1,
        ACT_DOUBLE = 3'd2,
        ACT_LONG   = 3'd3,
        ACT_LEFT   = 3'd4,
        ACT_RIGHT  = 3'd5,
        ACT_UP     = 3'd6,
        ACT_DOWN   = 3'd7
    } t_action;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DBL_PERIOD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PERIOD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_THR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_THR   = 3'd4;

    localparam logic [15:0] RST_DEBOUNCE    = 16'h0800;
    localparam logic [15:0] RST_DBL_PERIOD  = 16'h7FFF;
    localparam logic [15:0] RST_LONG_PERIOD = 16'hFFFF;
    // 40 deg/s in 1/16 deg/s, 0.5 g in 1/4096 g
    localparam logic [14:0] RST_GYRO_THR    = 15'd640;
    localparam logic [14:0] RST_TILT_THR    = 15'd2048;

    typedef struct packed {
        logic    flip;
        t_action act;
        logic    inv_next;
        logic    changed;
    } t_poll_res;

endpackage

// ===== rtl/core/cfgc_poll.sv =====
module cfgc_poll
    import cfgc_pkg::*;
(
    input  logic signed [15:0] i_rate_x,
    input  logic signed [15:0] i_rate_y,
    input  logic signed [15:0] i_tilt_x,
    input  logic [14:0]        i_gyro_thr,
    input  logic [14:0]        i_tilt_thr,
    input  logic               i_inverted,
    output t_poll_res          o_res
);

    logic signed [16:0] gt_pos;
    logic signed [16:0] gt_neg;
    logic signed [16:0] tt_pos;
    logic signed [16:0] tt_neg;
    logic signed [16:0] rx;
    logic signed [16:0] ry;
    logic signed [16:0] tx;

    assign gt_pos = signed'({2'b00, i_gyro_thr});
    assign gt_neg = -gt_pos;
    assign tt_pos = signed'({2'b00, i_tilt_thr});
    assign tt_neg = -tt_pos;
    assign rx     = signed'({i_rate_x[15], i_rate_x});
    assign ry     = signed'({i_rate_y[15], i_rate_y});
    assign tx     = signed'({i_tilt_x[15], i_tilt_x});

    always_comb begin
        o_res.flip     = 1'b1;
        o_res.act      = ACT_NONE;
        o_res.inv_next = i_inverted;
        o_res.changed  = 1'b0;
        // flip directions swap when the display is upside down
        priority if (rx > gt_pos) begin
            o_res.act = i_inverted ? ACT_LEFT : ACT_RIGHT;
        end else if (rx < gt_neg) begin
            o_res.act = i_inverted ? ACT_RIGHT : ACT_LEFT;
        end else if (ry > gt_pos) begin
            o_res.act = i_inverted ? ACT_DOWN : ACT_UP;
        end else if (ry < gt_neg) begin
            o_res.act = i_inverted ? ACT_UP : ACT_DOWN;
        end else begin
            o_res.flip = 1'b0;
            if (i_inverted && (tx > tt_pos)) begin
                o_res.inv_next = 1'b0;
                o_res.changed  = 1'b1;
            end else if (!i_inverted && (tx < tt_neg)) begin
                o_res.inv_next = 1'b1;
                o_res.changed  = 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/click_and_flip_gesture_classifier.sv =====
// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_ready    i_command i_pin_level i_rate_x i_rate_y
//                                                 i_tilt_x
// out       output     o_out_valid / i_out_ready  o_action o_inverted o_orientation_changed
// cfg       input      i_cfg_we                   i_cfg_idx i_cfg_data
//
// one beat in gives one beat out in the next cycle; a beat can enter every cycle unless a result is stalled
// the rate is set by the single result register, which is refilled when taken
// state and result are computed in one pass of compares and 16-bit increments
// reset is synchronous, active low, and restores the default register values
// a stalled result holds o_in_ready low until i_out_ready takes it
module click_and_flip_gesture_classifier
    import cfgc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_command,
    input  logic                  i_pin_level,
    input  logic signed [15:0]    i_rate_x,
    input  logic signed [15:0]    i_rate_y,
    input  logic signed [15:0]    i_tilt_x,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [2:0]            o_action,
    output logic                  o_inverted,
    output logic                  o_orientation_changed,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [15:0] r_debounce;
    logic [15:0] r_dbl_period;
    logic [15:0] r_long_period;
    logic [14:0] r_gyro_thr;
    logic [14:0] r_tilt_thr;

    logic [15:0] r_click_ctr, n_click_ctr;
    logic [15:0] r_hold_ctr, n_hold_ctr;
    logic        r_window_closed, n_window_closed;
    logic        r_hold_elapsed, n_hold_elapsed;
    logic [1:0]  r_pending, n_pending;
    logic        r_inverted, n_inverted;

    logic        r_out_valid;
    t_action     r_action, n_action;
    logic        r_out_inv;
    logic        r_changed, n_changed;

    logic        accept;
    t_poll_res   poll;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    cfgc_poll u_poll (
        .i_rate_x   (i_rate_x),
        .i_rate_y   (i_rate_y),
        .i_tilt_x   (i_tilt_x),
        .i_gyro_thr (r_gyro_thr),
        .i_tilt_thr (r_tilt_thr),
        .i_inverted (r_inverted),
        .o_res      (poll)
    );

    always_comb begin
        n_click_ctr     = r_click_ctr;
        n_hold_ctr      = r_hold_ctr;
        n_window_closed = r_window_closed;
        n_hold_elapsed  = r_hold_elapsed;
        n_pending       = r_pending;
        n_inverted      = r_inverted;
        n_action        = ACT_NONE;
        n_changed       = 1'b0;
        unique case (i_command)
            CMD_TICK: begin
                if (r_click_ctr >= r_dbl_period) begin
                    n_click_ctr     = '0;
                    n_window_closed = 1'b1;
                end else begin
                    n_click_ctr = r_click_ctr + 16'd1;
                end
                if (r_hold_ctr >= r_long_period) begin
                    n_hold_ctr     = '0;
                    n_hold_elapsed = 1'b1;
                end else begin
                    n_hold_ctr = r_hold_ctr + 16'd1;
                end
            end
            CMD_PIN: begin
                if (r_click_ctr > r_debounce) begin
                    if (!i_pin_level) begin
                        if (r_hold_elapsed) begin
                            n_pending = ACT_LONG[1:0];
                        end
                    end else begin
                        n_pending       = r_window_closed ? ACT_SINGLE[1:0] : ACT_DOUBLE[1:0];
                        n_click_ctr     = '0;
                        n_hold_ctr      = '0;
                        n_window_closed = 1'b0;
                        n_hold_elapsed  = 1'b0;
                    end
                end
            end
            CMD_POLL: begin
                if (poll.flip) begin
                    n_action = poll.act;
                end else begin
                    n_inverted = poll.inv_next;
                    n_changed  = poll.changed;
                    n_action   = t_action'({1'b0, r_pending});
                    n_pending  = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce    <= RST_DEBOUNCE;
            r_dbl_period  <= RST_DBL_PERIOD;
            r_long_period <= RST_LONG_PERIOD;
            r_gyro_thr    <= RST_GYRO_THR;
            r_tilt_thr    <= RST_TILT_THR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DEBOUNCE:    r_debounce    <= i_cfg_data;
                REG_DBL_PERIOD:  r_dbl_period  <= i_cfg_data;
                REG_LONG_PERIOD: r_long_period <= i_cfg_data;
                REG_GYRO_THR:    r_gyro_thr    <= i_cfg_data[14:0];
                REG_TILT_THR:    r_tilt_thr    <= i_cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_click_ctr     <= '0;
            r_hold_ctr      <= '0;
            r_window_closed <= 1'b0;
            r_hold_elapsed  <= 1'b0;
            r_pending       <= '0;
            r_inverted      <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (accept) begin
                r_click_ctr     <= n_click_ctr;
                r_hold_ctr      <= n_hold_ctr;
                r_window_closed <= n_window_closed;
                r_hold_elapsed  <= n_hold_elapsed;
                r_pending       <= n_pending;
                r_inverted      <= n_inverted;
                r_out_valid     <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted beat
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action  <= n_action;
            r_out_inv <= n_inverted;
            r_changed <= n_changed;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_action              = r_action;
    assign o_inverted            = r_out_inv;
    assign o_orientation_changed = r_changed;

endmodule

// ===== rtl/core/cfgc_checker.sv =====
`include "assert_macros.svh"

module cfgc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [2:0] o_action,
    input logic       o_orientation_changed
);

    // a stalled result stays
    `CFGC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // an empty output stage always takes a beat
    `CFGC_ASSERT_IMPL(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready)

    // every accepted beat shows a result on the next cycle
    `CFGC_ASSERT_NEXT(a_beat_to_result, i_clk, i_rst_n, i_in_valid && o_in_ready, o_out_valid)

    // an orientation change never comes with a flip gesture
    `CFGC_ASSERT_IMPL(a_change_no_flip, i_clk, i_rst_n, o_out_valid && o_orientation_changed,
        !o_action[2])

endmodule

bind click_and_flip_gesture_classifier cfgc_checker u_cfgc_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .i_in_valid            (i_in_valid),
    .o_in_ready            (o_in_ready),
    .o_out_valid           (o_out_valid),
    .i_out_ready           (i_out_ready),
    .o_action              (o_action),
    .o_orientation_changed (o_orientation_changed)
);
